// ===== src/tbt_pkg.sv =====
// ----------------------------------------------------------------------------
// tbt_pkg: shared types and constants of the thermistor beta converter
// widths, special-case path codes, ln table and normalize helper
// ----------------------------------------------------------------------------
package tbt_pkg;

   // converter sample width and derived widths
   localparam int SAMPLE_WIDTH = 16;
   localparam int REQ_DATA_W   = ((SAMPLE_WIDTH + 7) / 8) * 8;
   localparam int V_W          = SAMPLE_WIDTH + 3;     // magnitude of a, b
   localparam int FS           = (1 << (SAMPLE_WIDTH - 1)) - 1;

   // result widths
   localparam int TEMP_W     = 19;
   localparam int RSP_DATA_W = 24;

   // configuration
   localparam int GAIN_W     = 2;
   localparam int BETA_W     = 14;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 14;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_BETA = 1'b1;
   localparam logic [GAIN_W-1:0] GAIN_RESET = 2'd2;
   localparam logic [BETA_W-1:0] BETA_RESET = 14'd3977;

   // internal arithmetic widths
   localparam int P_W    = 5;
   localparam int IDX_W  = 5;
   localparam int REM_W  = 25;
   localparam int LO_W   = 16;
   localparam int PART_W = 12;
   localparam int LN_W   = 21;
   localparam int L_W    = 22;
   localparam int DEN_W  = 40;
   localparam int NB_W   = 29;
   localparam int N_W    = 54;
   localparam int Q_W    = 18;
   localparam int R_W    = DEN_W + Q_W;

   // fixed-point constants
   localparam int LN2_Q16      = 45426;
   localparam int T0_CENTI     = 29815;
   localparam int KELVIN_CENTI = 27315;
   localparam int TEMP_MIN     = -30000;
   localparam int TEMP_MAX     = 200000;

   // special-case path codes
   localparam int PATH_W = 2;
   localparam logic [PATH_W-1:0] PATH_NORMAL = 2'd0;
   localparam logic [PATH_W-1:0] PATH_COLD   = 2'd1;
   localparam logic [PATH_W-1:0] PATH_HOT    = 2'd2;
   localparam logic [PATH_W-1:0] PATH_INF    = 2'd3;

   typedef struct packed {
      logic [P_W-1:0]   p;
      logic [IDX_W-1:0] idx;
      logic [REM_W-1:0] rem;
   } norm_type;

   typedef struct packed {
      logic [PATH_W-1:0]     path;
      logic signed [L_W-1:0] l;
   } ln_item_type;

   // ln(1 + k/32) in Q16
   function automatic logic [LO_W-1:0] ln_entry(input logic [IDX_W:0] k);
      logic [LO_W-1:0] r;
      case (k)
         6'd0:  r = 16'd0;
         6'd1:  r = 16'd2017;
         6'd2:  r = 16'd3973;
         6'd3:  r = 16'd5873;
         6'd4:  r = 16'd7719;
         6'd5:  r = 16'd9515;
         6'd6:  r = 16'd11262;
         6'd7:  r = 16'd12965;
         6'd8:  r = 16'd14624;
         6'd9:  r = 16'd16242;
         6'd10: r = 16'd17821;
         6'd11: r = 16'd19364;
         6'd12: r = 16'd20870;
         6'd13: r = 16'd22343;
         6'd14: r = 16'd23783;
         6'd15: r = 16'd25193;
         6'd16: r = 16'd26573;
         6'd17: r = 16'd27926;
         6'd18: r = 16'd29248;
         6'd19: r = 16'd30546;
         6'd20: r = 16'd31818;
         6'd21: r = 16'd33067;
         6'd22: r = 16'd34292;
         6'd23: r = 16'd35494;
         6'd24: r = 16'd36675;
         6'd25: r = 16'd37835;
         6'd26: r = 16'd38975;
         6'd27: r = 16'd40095;
         6'd28: r = 16'd41196;
         6'd29: r = 16'd42280;
         6'd30: r = 16'd43345;
         6'd31: r = 16'd44394;
         6'd32: r = 16'd45426;
         default: r = 16'd0;
      endcase
      return r;
   endfunction

   // split v into exponent and 30-bit mantissa fraction
   function automatic norm_type normalize(input logic [V_W-1:0] v);
      norm_type r;
      logic [P_W-1:0] p;
      logic [V_W+29:0] sh;
      p = '0;
      for (int i = 0; i < V_W; i++) begin
         if (v[i]) p = P_W'(i);
      end
      sh = {30'b0, v} << (P_W'(30) - p);
      r.p = p;
      r.idx = sh[29:25];
      r.rem = sh[24:0];
      return r;
   endfunction

endpackage

// ===== src/tbt_log_unit.sv =====
// ----------------------------------------------------------------------------
// tbt_log_unit: bridge terms and log of the resistance ratio
// four stages: a/b terms, normalize, table interpolate, ln difference
// ----------------------------------------------------------------------------
module tbt_log_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [tbt_pkg::GAIN_W-1:0]       gain,
   input  logic                             in_valid,
   output logic                             in_ready,
   input  logic signed [tbt_pkg::SAMPLE_WIDTH-1:0] in_raw,
   output logic                             out_valid,
   input  logic                             out_ready,
   output tbt_pkg::ln_item_type             out_item
);
   import tbt_pkg::*;

   localparam int NS = 4;

   logic [NS-1:0] valid_ff;
   logic [NS-1:0] rdy;
   logic [NS-1:0] vin;

   // stage payloads
   logic [PATH_W-1:0] path0_ff, path0_in, path1_ff, path2_ff;
   logic signed [V_W:0] a0_ff, b0_ff, a0_in, b0_in;
   norm_type na1_ff, nb1_ff;
   logic [P_W-1:0] pa2_ff, pb2_ff;
   logic [LO_W-1:0] loa2_ff, lob2_ff;
   logic [PART_W-1:0] pta2_ff, ptb2_ff, pta2_in, ptb2_in;
   ln_item_type item3_ff, item3_in;

   // ready chain, bubbles collapse
   always_comb begin
      rdy[NS-1] = !valid_ff[NS-1] || out_ready;
      for (int k = NS - 2; k >= 0; k--) rdy[k] = !valid_ff[k] || rdy[k+1];
      vin[0] = in_valid;
      for (int k = 1; k < NS; k++) vin[k] = valid_ff[k-1];
   end

   assign in_ready = rdy[0];
   assign out_valid = valid_ff[NS-1];
   assign out_item = item3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < NS; k++) if (rdy[k]) valid_ff[k] <= vin[k];
      end
   end

   // stage 0: a = d - 2 raw, b = d + 2 raw
   always_comb begin
      logic signed [V_W:0] d_s;
      logic signed [V_W:0] r2_s;
      d_s = (V_W+1)'(FS) <<< gain;
      r2_s = (V_W+1)'(in_raw) <<< 1;
      a0_in = d_s - r2_s;
      b0_in = d_s + r2_s;
      if (b0_in <= 0) path0_in = PATH_COLD;
      else if (a0_in <= 0) path0_in = PATH_HOT;
      else path0_in = PATH_NORMAL;
   end

   // stage 2: table lookup and linear interpolation
   function automatic logic [PART_W-1:0] interp(input norm_type n);
      logic [LO_W-1:0] lo, hi;
      logic [LO_W+REM_W:0] prod;
      lo = ln_entry({1'b0, n.idx});
      hi = ln_entry({1'b0, n.idx} + 6'd1);
      prod = (LO_W+REM_W+1)'(hi - lo) * (LO_W+REM_W+1)'(n.rem) + (LO_W+REM_W+1)'(1 << 24);
      return prod[REM_W+PART_W-1:REM_W];
   endfunction

   assign pta2_in = interp(na1_ff);
   assign ptb2_in = interp(nb1_ff);

   // stage 3: ln(a) - ln(b)
   always_comb begin
      logic [LN_W-1:0] lna, lnb;
      lna = LN_W'(pa2_ff) * LN_W'(LN2_Q16) + LN_W'(loa2_ff) + LN_W'(pta2_ff);
      lnb = LN_W'(pb2_ff) * LN_W'(LN2_Q16) + LN_W'(lob2_ff) + LN_W'(ptb2_ff);
      item3_in.path = path2_ff;
      item3_in.l = $signed({1'b0, lna}) - $signed({1'b0, lnb});
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         a0_ff <= a0_in;
         b0_ff <= b0_in;
         path0_ff <= path0_in;
      end
      if (rdy[1]) begin
         na1_ff <= normalize(a0_ff[V_W-1:0]);
         nb1_ff <= normalize(b0_ff[V_W-1:0]);
         path1_ff <= path0_ff;
      end
      if (rdy[2]) begin
         pa2_ff <= na1_ff.p;
         pb2_ff <= nb1_ff.p;
         loa2_ff <= ln_entry({1'b0, na1_ff.idx});
         lob2_ff <= ln_entry({1'b0, nb1_ff.idx});
         pta2_ff <= pta2_in;
         ptb2_ff <= ptb2_in;
         path2_ff <= path1_ff;
      end
      if (rdy[3]) item3_ff <= item3_in;
   end

endmodule

// ===== src/tbt_div_unit.sv =====
// ----------------------------------------------------------------------------
// tbt_div_unit: beta equation division and output formatting
// numerator/denominator stages, one quotient bit per stage, clamp stage
// ----------------------------------------------------------------------------
module tbt_div_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [tbt_pkg::BETA_W-1:0]       beta,
   input  logic                             in_valid,
   output logic                             in_ready,
   input  tbt_pkg::ln_item_type             in_item,
   output logic                             out_valid,
   input  logic                             out_ready,
   output logic signed [tbt_pkg::TEMP_W-1:0] out_temp,
   output logic                             out_flag
);
   import tbt_pkg::*;

   localparam int NS = 4 + Q_W + 1;
   localparam int DS = 4;             // first quotient stage
   localparam int OS = NS - 1;        // output stage

   typedef struct packed {
      logic [PATH_W-1:0] path;
      logic [R_W-1:0]    rem;
      logic [R_W-1:0]    den;
      logic [Q_W-1:0]    q;
   } div_stage_type;

   logic [NS-1:0] valid_ff;
   logic [NS-1:0] rdy;
   logic [NS-1:0] vin;

   logic [PATH_W-1:0] path0_ff, path1_ff, path2_ff, path1_in;
   logic signed [DEN_W-1:0] den0_ff, den0_in, den1_ff;
   logic [NB_W-1:0] nb0_ff, nb0_in;
   logic [N_W-1:0] num1_ff, num1_in, n2_ff, n2_in;
   logic [R_W-1:0] den2_ff;
   div_stage_type st_ff [Q_W+1];
   div_stage_type st_in [Q_W+1];
   logic signed [TEMP_W-1:0] temp_ff, temp_in;
   logic flag_ff, flag_in;

   // ready chain, bubbles collapse
   always_comb begin
      rdy[NS-1] = !valid_ff[NS-1] || out_ready;
      for (int k = NS - 2; k >= 0; k--) rdy[k] = !valid_ff[k] || rdy[k+1];
      vin[0] = in_valid;
      for (int k = 1; k < NS; k++) vin[k] = valid_ff[k-1];
   end

   assign in_ready = rdy[0];
   assign out_valid = valid_ff[OS];
   assign out_temp = temp_ff;
   assign out_flag = flag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < NS; k++) if (rdy[k]) valid_ff[k] <= vin[k];
      end
   end

   // stage 0: den = L*T0 + beta*100*2^16, partial numerator beta*T0
   always_comb begin
      logic [BETA_W+6:0] b100;
      b100 = (BETA_W+7)'(beta) * (BETA_W+7)'(100);
      den0_in = DEN_W'(in_item.l) * DEN_W'(T0_CENTI) +
                $signed(DEN_W'({b100, 16'b0}));
      nb0_in = NB_W'(beta) * NB_W'(T0_CENTI);
   end

   // stage 1: full numerator, infinite temperature when den <= 0
   always_comb begin
      logic [NB_W+6:0] nb100;
      nb100 = (NB_W+7)'(nb0_ff) * (NB_W+7)'(100);
      num1_in = N_W'({nb100, 16'b0});
      path1_in = path0_ff;
      if (path0_ff == PATH_NORMAL && den0_ff <= 0) path1_in = PATH_INF;
   end

   // stage 2: rounding bias
   assign n2_in = num1_ff + N_W'(den1_ff[DEN_W-1:1]);

   // stage 3 and quotient stages: restoring division, msb first
   always_comb begin
      logic [R_W-1:0] sh;
      st_in[0].rem = R_W'(n2_ff);
      st_in[0].den = den2_ff;
      st_in[0].q = '0;
      st_in[0].path = path2_ff;
      if (path2_ff == PATH_NORMAL && R_W'(n2_ff) >= (den2_ff << Q_W))
         st_in[0].path = PATH_INF;
      for (int k = 0; k < Q_W; k++) begin
         st_in[k+1] = st_ff[k];
         sh = st_ff[k].den << (Q_W - 1 - k);
         if (st_ff[k].rem >= sh) begin
            st_in[k+1].rem = st_ff[k].rem - sh;
            st_in[k+1].q[Q_W-1-k] = 1'b1;
         end
      end
   end

   // output stage: kelvin offset, clamp, special cases
   always_comb begin
      logic signed [Q_W+1:0] t;
      t = $signed({2'b0, st_ff[Q_W].q}) - (Q_W+2)'(KELVIN_CENTI);
      flag_in = 1'b0;
      case (st_ff[Q_W].path)
         PATH_NORMAL: begin
            if (t > (Q_W+2)'(TEMP_MAX)) temp_in = TEMP_W'(TEMP_MAX);
            else if (t < $signed((Q_W+2)'(TEMP_MIN))) temp_in = TEMP_W'(TEMP_MIN);
            else temp_in = TEMP_W'(t);
         end
         PATH_COLD: begin
            temp_in = TEMP_W'(TEMP_MIN);
            flag_in = 1'b1;
         end
         PATH_HOT: begin
            temp_in = TEMP_W'(TEMP_MAX);
            flag_in = 1'b1;
         end
         default: temp_in = TEMP_W'(TEMP_MAX);
      endcase
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         den0_ff <= den0_in;
         nb0_ff <= nb0_in;
         path0_ff <= in_item.path;
      end
      if (rdy[1]) begin
         num1_ff <= num1_in;
         den1_ff <= den0_ff;
         path1_ff <= path1_in;
      end
      if (rdy[2]) begin
         n2_ff <= n2_in;
         den2_ff <= R_W'(den1_ff[DEN_W-2:0]);
         path2_ff <= path1_ff;
      end
      for (int k = 0; k <= Q_W; k++) if (rdy[DS-1+k]) st_ff[k] <= st_in[k];
      if (rdy[OS]) begin
         temp_ff <= temp_in;
         flag_ff <= flag_in;
      end
   end

   // flagged results sit at one end of the range
   a_flag_end: assert property (@(posedge clock) disable iff (reset)
      out_valid && out_flag |-> out_temp == TEMP_W'(TEMP_MIN) ||
                                 out_temp == TEMP_W'(TEMP_MAX))
      else $error("flagged result not saturated");

   // every result within the saturation range
   a_temp_range: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> out_temp >= $signed(TEMP_W'(TEMP_MIN)) &&
                    out_temp <= $signed(TEMP_W'(TEMP_MAX)))
      else $error("temperature outside range");

   // remainder of a finished division is below the divisor
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      valid_ff[OS-1] && st_ff[Q_W].path == PATH_NORMAL |->
         st_ff[Q_W].rem < st_ff[Q_W].den)
      else $error("division remainder not reduced");

   // a stalled result stays put
   a_hold: assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_ready |=> out_valid && $stable(out_temp) && $stable(out_flag))
      else $error("stalled result changed");

endmodule

// ===== src/thermistor_beta_temperature.sv =====
// ----------------------------------------------------------------------------
// thermistor_beta_temperature: half-bridge reading to temperature
// beta equation in fixed point, fully pipelined
// ----------------------------------------------------------------------------
//  channel  direction  ports              contents
//  req      in         req_t*             raw_sample
//  rsp      out        rsp_t*             temp_centi, out_of_range
//  csr      in         csr_we/index/wdata gain_code, beta_kelvin
//
// one request per cycle while responses are taken; pipe of 4 log stages,
// 4 numerator stages, 18 one-bit division stages, 1 output stage
// synchronous active-high reset empties the pipe and loads register defaults
// a stalled response backs up stage by stage; empty stages keep filling
// ----------------------------------------------------------------------------
module thermistor_beta_temperature (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [tbt_pkg::REQ_DATA_W-1:0]     req_tdata,   // raw_sample
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [tbt_pkg::RSP_DATA_W-1:0]     rsp_tdata,   // temp_centi
   output logic                               rsp_tuser,   // out_of_range
   input  logic                               csr_we,
   input  logic [tbt_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [tbt_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import tbt_pkg::*;

   logic [GAIN_W-1:0] gain_ff;
   logic [BETA_W-1:0] beta_ff;
   logic mid_valid, mid_ready;
   ln_item_type mid_item;
   logic signed [TEMP_W-1:0] temp;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= GAIN_RESET;
         beta_ff <= BETA_RESET;
      end else if (csr_we) begin
         case (csr_index)
            REG_GAIN: gain_ff <= csr_wdata[GAIN_W-1:0];
            REG_BETA: beta_ff <= csr_wdata[BETA_W-1:0];
            default: ;
         endcase
      end
   end

   // log of the resistance ratio
   tbt_log_unit u_log (
      .clock     (clock),
      .reset     (reset),
      .gain      (gain_ff),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_raw    ($signed(req_tdata[SAMPLE_WIDTH-1:0])),
      .out_valid (mid_valid),
      .out_ready (mid_ready),
      .out_item  (mid_item)
   );

   // beta equation and clamp
   tbt_div_unit u_div (
      .clock     (clock),
      .reset     (reset),
      .beta      (beta_ff),
      .in_valid  (mid_valid),
      .in_ready  (mid_ready),
      .in_item   (mid_item),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_temp  (temp),
      .out_flag  (rsp_tuser)
   );

   assign rsp_tdata = {{(RSP_DATA_W-TEMP_W){1'b0}}, temp};

endmodule
